// ===== hw/rtl/stable_descending_selection_sort_unit_assert.svh =====
// Assertion macros for the stable descending selection sort unit.
// Depends on a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef STABLE_DESCENDING_SELECTION_SORT_UNIT_ASSERT_SVH
`define STABLE_DESCENDING_SELECTION_SORT_UNIT_ASSERT_SVH

// Check a property on every rising edge outside reset
`define SDSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define SDSS_ASSERT_IMPL(label, ante, cons, msg) \
    `SDSS_ASSERT(label, (ante) |-> (cons), msg)

// Check that an antecedent implies a consequent in the next cycle
`define SDSS_ASSERT_NEXT(label, ante, cons, msg) \
    `SDSS_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== hw/rtl/sdss_pkg.sv =====
// Package for the stable descending selection sort unit.
// Holds store sizing, field widths and the control state type; no dependencies.
package sdss_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int TAG_W       = 16;
    localparam int WORD_W      = KEY_W + TAG_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } sort_state_t;

endpackage

// ===== hw/rtl/stable_descending_selection_sort_unit.sv =====
// Stable descending selection sort unit: loads records into an on-chip store and emits them
// by key, largest first. Depends on sdss_pkg and stable_descending_selection_sort_unit_assert.svh.
//
// Usage: a word is taken at a rising edge with start high and busy low; a load takes one
// cycle and busy stays low, so records may be loaded back to back. A word with set_end high
// ends the set (it is stored first unless the store already holds STORE_DEPTH records, in
// which case it is dropped and overflowed is raised on every result of the set). busy then
// rises and the n stored records leave in descending signed Q16.16 key order, equal keys in
// arrival order. Each result is on the result ports for exactly one cycle with strobe high;
// the receiver cannot stall, so it must take every strobed word. Finding one result is a
// full scan of the record memory through its single read port: n reads, then a drain state
// that waits on the registered read data, then the emit state. run_last marks the final
// result; busy falls in the cycle after it.
`include "stable_descending_selection_sort_unit_assert.svh"

module stable_descending_selection_sort_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [sdss_pkg::KEY_W-1:0] fitness_key,
    input  logic        [sdss_pkg::TAG_W-1:0] payload_tag,
    input  logic                              set_end,
    output logic                              strobe,
    output logic signed [sdss_pkg::KEY_W-1:0] sorted_key,
    output logic        [sdss_pkg::TAG_W-1:0] sorted_tag,
    output logic                              run_last,
    output logic                              overflowed
);

    sdss_pkg::sort_state_t state_reg, state_next;

    logic [sdss_pkg::CNT_W-1:0]       fill_count_reg, fill_count_next;
    logic                             drop_seen_reg, drop_seen_next;
    logic [sdss_pkg::STORE_DEPTH-1:0] taken_reg, taken_next;
    logic [sdss_pkg::IDX_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                             cmp_vld_reg, cmp_vld_next;
    logic [sdss_pkg::IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                             have_reg, have_next;
    logic signed [sdss_pkg::KEY_W-1:0] best_key_reg, best_key_next;
    logic [sdss_pkg::TAG_W-1:0]       best_tag_reg, best_tag_next;
    logic [sdss_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [sdss_pkg::IDX_W-1:0]       emit_cnt_reg, emit_cnt_next;

    logic [sdss_pkg::WORD_W-1:0]      mem [sdss_pkg::STORE_DEPTH];
    logic [sdss_pkg::WORD_W-1:0]      rd_data_reg;

    logic                             accept;
    logic                             wr_en;
    logic                             rd_en;
    logic [sdss_pkg::CNT_W-1:0]       last_pos;
    logic                             scan_last;
    logic                             emit_last;
    logic signed [sdss_pkg::KEY_W-1:0] rd_key;
    logic [sdss_pkg::TAG_W-1:0]       rd_tag;
    logic                             cand;

    // Decode handshake and position flags
    assign accept    = start && !busy;
    assign wr_en     = accept && (fill_count_reg < sdss_pkg::CNT_W'(sdss_pkg::STORE_DEPTH));
    assign rd_en     = (state_reg == sdss_pkg::ST_SCAN);
    assign last_pos  = fill_count_reg - sdss_pkg::CNT_W'(1);
    assign scan_last = ({1'b0, scan_idx_reg} == last_pos);
    assign emit_last = ({1'b0, emit_cnt_reg} == last_pos);
    assign rd_key    = rd_data_reg[sdss_pkg::WORD_W-1 -: sdss_pkg::KEY_W];
    assign rd_tag    = rd_data_reg[sdss_pkg::TAG_W-1:0];

    // Keep the first remaining maximum: replace only on a strictly larger key
    assign cand = cmp_vld_reg && !taken_reg[cmp_idx_reg]
                  && (!have_reg || (rd_key > best_key_reg));

    // Record memory: one write port for loads, one registered read port for scans
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[fill_count_reg[sdss_pkg::IDX_W-1:0]] <= {fitness_key, payload_tag};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdss_pkg::ST_IDLE:
            begin
                if (accept && set_end)
                begin
                    state_next = sdss_pkg::ST_SCAN;
                end
            end
            sdss_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = sdss_pkg::ST_DRAIN;
                end
            end
            sdss_pkg::ST_DRAIN:
            begin
                state_next = sdss_pkg::ST_EMIT;
            end
            sdss_pkg::ST_EMIT:
            begin
                state_next = emit_last ? sdss_pkg::ST_IDLE : sdss_pkg::ST_SCAN;
            end
            default:
            begin
                state_next = sdss_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        busy   = 1'b1;
        strobe = 1'b0;
        unique case (state_reg) inside
            sdss_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            sdss_pkg::ST_SCAN, sdss_pkg::ST_DRAIN:
            begin
                busy = 1'b1;
            end
            sdss_pkg::ST_EMIT:
            begin
                strobe = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // Drive the result word from the winner registers
    assign sorted_key = best_key_reg;
    assign sorted_tag = best_tag_reg;
    assign run_last   = strobe && emit_last;
    assign overflowed = drop_seen_reg;

    // Datapath next values: load counters, scan pointer, compare stage, winner
    always_comb
    begin
        fill_count_next = fill_count_reg;
        drop_seen_next  = drop_seen_reg;
        taken_next      = taken_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = rd_en;
        cmp_idx_next    = scan_idx_reg;
        have_next       = have_reg;
        best_key_next   = best_key_reg;
        best_tag_next   = best_tag_reg;
        best_idx_next   = best_idx_reg;
        emit_cnt_next   = emit_cnt_reg;

        // Count stored records, flag drops
        if (wr_en)
        begin
            fill_count_next = fill_count_reg + sdss_pkg::CNT_W'(1);
        end
        else if (accept)
        begin
            drop_seen_next = 1'b1;
        end

        // Advance the read pointer
        if (rd_en)
        begin
            scan_idx_next = scan_last ? '0 : scan_idx_reg + sdss_pkg::IDX_W'(1);
        end

        // Capture a better candidate
        if (cand)
        begin
            have_next     = 1'b1;
            best_key_next = rd_key;
            best_tag_next = rd_tag;
            best_idx_next = cmp_idx_reg;
        end

        // Retire the winner; empty the store after the final one
        if (state_reg == sdss_pkg::ST_EMIT)
        begin
            have_next = 1'b0;
            if (emit_last)
            begin
                taken_next      = '0;
                fill_count_next = '0;
                drop_seen_next  = 1'b0;
                emit_cnt_next   = '0;
            end
            else
            begin
                taken_next[best_idx_reg] = 1'b1;
                emit_cnt_next = emit_cnt_reg + sdss_pkg::IDX_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sdss_pkg::ST_IDLE;
            fill_count_reg <= '0;
            drop_seen_reg  <= 1'b0;
            taken_reg      <= '0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            have_reg       <= 1'b0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            drop_seen_reg  <= drop_seen_next;
            taken_reg      <= taken_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            have_reg       <= have_next;
            emit_cnt_reg   <= emit_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        best_key_reg <= best_key_next;
        best_tag_reg <= best_tag_next;
        best_idx_reg <= best_idx_next;
    end

    `SDSS_ASSERT_IMPL(a_strobe_busy, strobe, busy && have_reg, "result strobed without a winner")
    `SDSS_ASSERT_IMPL(a_winner_fresh, strobe, !taken_reg[best_idx_reg], "winner already emitted")
    `SDSS_ASSERT_NEXT(a_last_frees, run_last, !busy && (fill_count_reg == '0), "store not emptied")
    `SDSS_ASSERT(a_fill_bound, fill_count_reg <= sdss_pkg::CNT_W'(sdss_pkg::STORE_DEPTH), "overfilled")
    `SDSS_ASSERT_IMPL(a_idle_clear, !busy, (taken_reg == '0) && !cmp_vld_reg, "idle with marks set")

endmodule

// ===== test/stable_descending_selection_sort_unit_tb.sv =====
// Self-checking testbench for the stable descending selection sort unit.
// Depends on sdss_pkg and the unit's RTL; predicts each sorted run and checks every result word.
`timescale 1ns / 1ps

module stable_descending_selection_sort_unit_tb;

    // One record word waiting to be sent, with its pacing controls
    typedef struct {
        logic signed [sdss_pkg::KEY_W-1:0] key;
        logic        [sdss_pkg::TAG_W-1:0] tag;
        logic                              last;
        int unsigned                       idle_pct;
        bit                                drain_first;
    } record_word_t;

    // One sorted word that the unit owes us
    typedef struct {
        logic signed [sdss_pkg::KEY_W-1:0] key;
        logic        [sdss_pkg::TAG_W-1:0] tag;
        logic                              run_last;
        logic                              ovf;
    } sorted_word_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic signed [sdss_pkg::KEY_W-1:0] fitness_key = '0;
    logic        [sdss_pkg::TAG_W-1:0] payload_tag = '0;
    logic                              set_end = 1'b0;
    logic                              busy;
    logic                              strobe;
    logic signed [sdss_pkg::KEY_W-1:0] sorted_key;
    logic        [sdss_pkg::TAG_W-1:0] sorted_tag;
    logic                              run_last;
    logic                              overflowed;

    record_word_t            outgoing_records[$];
    sorted_word_t            sorted_due[$];

    // Predictor copy of the record store
    logic signed [sdss_pkg::KEY_W-1:0] held_keys [sdss_pkg::STORE_DEPTH];
    logic        [sdss_pkg::TAG_W-1:0] held_tags [sdss_pkg::STORE_DEPTH];
    int                      held_count = 0;
    bit                      set_dropped = 1'b0;

    int                      mismatch_count = 0;
    int                      records_sent = 0;
    int                      sets_sorted = 0;
    int                      overflow_sets = 0;
    int                      words_checked = 0;
    int                      queued_count = 0;

    stable_descending_selection_sort_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .fitness_key (fitness_key),
        .payload_tag (payload_tag),
        .set_end     (set_end),
        .strobe      (strobe),
        .sorted_key  (sorted_key),
        .sorted_tag  (sorted_tag),
        .run_last    (run_last),
        .overflowed  (overflowed)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Store one accepted record; on the set's last word, queue the whole run largest first
    function automatic void absorb_record(logic signed [sdss_pkg::KEY_W-1:0] key,
                                          logic [sdss_pkg::TAG_W-1:0] tag, logic last);
        bit           taken [sdss_pkg::STORE_DEPTH];
        int           best;
        sorted_word_t word;
        if (held_count < sdss_pkg::STORE_DEPTH)
        begin
            held_keys[held_count] = key;
            held_tags[held_count] = tag;
            held_count++;
        end
        else
            set_dropped = 1'b1;
        if (!last)
            return;
        foreach (taken[i])
            taken[i] = 1'b0;
        // first maximum wins, so equal keys leave in arrival order
        for (int k = 0; k < held_count; k++)
        begin
            best = -1;
            for (int i = 0; i < held_count; i++)
                if (!taken[i] && (best < 0 || held_keys[i] > held_keys[best]))
                    best = i;
            taken[best]   = 1'b1;
            word.key      = held_keys[best];
            word.tag      = held_tags[best];
            word.run_last = (k == held_count - 1);
            word.ovf      = set_dropped;
            sorted_due.insert(sorted_due.size(), word);
        end
        sets_sorted++;
        if (set_dropped)
            overflow_sets++;
        held_count  = 0;
        set_dropped = 1'b0;
    endfunction

    // Pacing per phase: none, sender idle 47%, none, sender idle 15%
    function automatic int unsigned phase_idle_pct(int idx);
        case ((idx / 45) % 4)
            1:       return 47;
            3:       return 15;
            default: return 0;
        endcase
    endfunction

    function automatic void queue_record(logic signed [sdss_pkg::KEY_W-1:0] key,
                                         logic [sdss_pkg::TAG_W-1:0] tag,
                                         logic last, int unsigned pct, bit drain);
        record_word_t rec;
        rec.key         = key;
        rec.tag         = tag;
        rec.last        = last;
        rec.idle_pct    = pct;
        rec.drain_first = drain;
        outgoing_records.insert(outgoing_records.size(), rec);
        queued_count++;
    endfunction

    // Mix wide random keys with a small pool that forces ties, plus the extremes
    function automatic logic signed [sdss_pkg::KEY_W-1:0] draw_key();
        case ($urandom_range(3)) inside
            0, 1:    return $urandom;
            2:       return $signed($urandom_range(4)) - 2 <<< 16;
            default:
                case ($urandom_range(3))
                    0:       return 32'sh7FFF_FFFF;
                    1:       return 32'sh8000_0000;
                    2:       return '0;
                    default: return -1;
                endcase
        endcase
    endfunction

    function automatic void queue_random_set(int size, bit drain);
        for (int i = 0; i < size; i++)
            queue_record(draw_key(), sdss_pkg::TAG_W'($urandom), (i == size - 1),
                         phase_idle_pct(queued_count), drain && (i == 0));
    endfunction

    // Print one mismatch line and count it
    task automatic report_mismatch(string what);
        $display("MISMATCH %s", what);
        mismatch_count++;
    endtask

    // Driver: take the presented word when accepted, then present the next or idle
    always @(posedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else
        begin
            if (start && !busy)
            begin
                absorb_record(fitness_key, payload_tag, set_end);
                records_sent++;
            end
            if (!start || !busy)
            begin
                if (outgoing_records.size() != 0
                    && !(outgoing_records[0].drain_first && sorted_due.size() != 0)
                    && $urandom_range(99) >= outgoing_records[0].idle_pct)
                begin
                    fitness_key <= outgoing_records[0].key;
                    payload_tag <= outgoing_records[0].tag;
                    set_end     <= outgoing_records[0].last;
                    start       <= 1'b1;
                    void'(outgoing_records.pop_front());
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed word must match the oldest owed word
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (sorted_due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result word: key %0h tag %0h",
                                          sorted_key, sorted_tag));
            end
            else
            begin
                if (sorted_key !== sorted_due[0].key)
                    report_mismatch($sformatf("sorted_key on result word %0d: got %0h, expected %0h",
                                              words_checked, sorted_key, sorted_due[0].key));
                if (sorted_tag !== sorted_due[0].tag)
                    report_mismatch($sformatf("sorted_tag on result word %0d: got %0h, expected %0h",
                                              words_checked, sorted_tag, sorted_due[0].tag));
                if (run_last !== sorted_due[0].run_last)
                    report_mismatch($sformatf("run_last on result word %0d: got %0h, expected %0h",
                                              words_checked, run_last, sorted_due[0].run_last));
                if (overflowed !== sorted_due[0].ovf)
                    report_mismatch($sformatf("overflowed on result word %0d: got %0h, expected %0h",
                                              words_checked, overflowed, sorted_due[0].ovf));
                void'(sorted_due.pop_front());
                words_checked++;
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        // single-record set at the top key with an all-ones tag
        queue_record(32'sh7FFF_FFFF, 16'hFFFF, 1'b1, 0, 1'b0);
        // extremes of the key range, ties on 0, 1.0 and the minimum
        queue_record(32'sh0000_0000, 16'h0000, 1'b0, 0, 1'b0);
        queue_record(-32'sd1,        16'h0011, 1'b0, 0, 1'b0);
        queue_record(32'sh8000_0000, 16'h0022, 1'b0, 0, 1'b0);
        queue_record(32'sh7FFF_FFFF, 16'h0033, 1'b0, 0, 1'b0);
        queue_record(32'sh0001_0000, 16'h0044, 1'b0, 0, 1'b0);
        queue_record(32'sh0001_0000, 16'h0055, 1'b0, 0, 1'b0);
        queue_record(32'shFFFF_0000, 16'h0066, 1'b0, 0, 1'b0);
        queue_record(32'sh0000_0000, 16'h0077, 1'b0, 0, 1'b0);
        queue_record(32'sh8000_0000, 16'hFFFF, 1'b1, 0, 1'b0);
        // two equal keys after a full drain: stability in the smallest case
        queue_record(32'sh1234_5678, 16'hAAAA, 1'b0, 0, 1'b1);
        queue_record(32'sh1234_5678, 16'h5555, 1'b1, 0, 1'b0);

        // overflow with the set_end word itself dropped, then an exactly full store
        queue_random_set(35, 1'b1);
        queue_random_set(sdss_pkg::STORE_DEPTH, 1'b0);
        while (queued_count < 310)
        begin
            if ($urandom_range(9) == 0)
                queue_random_set($urandom_range(30, 36), $urandom_range(19) == 0);
            else
                queue_random_set($urandom_range(1, 8), $urandom_range(19) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // hold until every word is sent and every owed result has arrived
        while (outgoing_records.size() != 0 || start || sorted_due.size() != 0)
            @(posedge clk);
        repeat (2 * sdss_pkg::STORE_DEPTH + 8) @(posedge clk);
        if (sorted_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d result words never arrived", sorted_due.size()));
        end

        $display("Sent %0d records in %0d sets (%0d with dropped records); checked %0d words.",
                 records_sent, sets_sorted, overflow_sets, words_checked);
        $display("Mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("stable_descending_selection_sort_unit regression: pass");
        else
            $display("stable_descending_selection_sort_unit regression: fail");
        $finish;
    end

    // Watchdog for a hung handshake
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d records queued and %0d results owed",
                 outgoing_records.size(), sorted_due.size());
        $display("stable_descending_selection_sort_unit regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/sdss_pkg.sv
hw/rtl/stable_descending_selection_sort_unit.sv
test/stable_descending_selection_sort_unit_tb.sv
